/* rtl/ascip_pkg.sv */
// ascip_pkg: shared types, codes and helper functions for the alphabet shift cipher.
// Used by alphabet_shift_cipher_core. No dependencies.
`default_nettype none

package ascip_pkg;

  // Command codes
  localparam logic [1:0] CMD_KEY     = 2'd0;
  localparam logic [1:0] CMD_ENCRYPT = 2'd1;
  localparam logic [1:0] CMD_DECRYPT = 2'd2;

  // Alphabet codes (code 3 falls back to digits)
  localparam logic [1:0] ALPHA_DIGITS = 2'd0;
  localparam logic [1:0] ALPHA_LCASE  = 2'd1;
  localparam logic [1:0] ALPHA_MIXED  = 2'd2;

  localparam logic [5:0] LEN_DIGITS = 6'd10;
  localparam logic [5:0] LEN_LOWER  = 6'd26;
  localparam logic [5:0] LEN_MIXED  = 6'd62;

  // floor(2^12 / len), reciprocal for the shift residue
  localparam int unsigned RECIP_SHIFT = 12;
  localparam logic [8:0] RECIP_DIGITS = 9'(4096 / 10);
  localparam logic [8:0] RECIP_LOWER  = 9'(4096 / 26);
  localparam logic [8:0] RECIP_MIXED  = 9'(4096 / 62);

  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;
  localparam logic [7:0] CH_LOWA   = 8'h61;
  localparam logic [7:0] CH_LOWZ   = 8'h7a;
  localparam logic [7:0] CH_UPA    = 8'h41;
  localparam logic [7:0] CH_UPZ    = 8'h5a;

  localparam logic [7:0] HASH_MULT = 8'd31;

  typedef struct packed {
    logic [1:0] command;
    logic       key_start;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       mapped;
  } result_t;

  typedef struct packed {
    logic       found;
    logic [5:0] pos;
  } lookup_t;

  function automatic logic [5:0] alphabet_size(input logic [1:0] sel);
    logic [5:0] len;
    case (sel)
      ALPHA_LCASE: len = LEN_LOWER;
      ALPHA_MIXED: len = LEN_MIXED;
      default:     len = LEN_DIGITS;
    endcase
    return len;
  endfunction

  // x mod len for x up to 256: reciprocal multiply, then one correction
  function automatic logic [5:0] mod_const(input logic [8:0] x, input logic [5:0] len,
                                           input logic [8:0] recip);
    logic [17:0] prod;
    logic [4:0]  quot;
    logic [10:0] back;
    logic [8:0]  rem;
    prod = 18'(x) * 18'(recip);
    quot = prod[RECIP_SHIFT+4:RECIP_SHIFT];
    back = 11'(quot) * 11'(len);
    rem  = x - back[8:0];
    if (rem >= 9'(len)) begin
      rem = rem - 9'(len);
    end
    return rem[5:0];
  endfunction

  // Position of a byte in the selected alphabet
  function automatic lookup_t char_pos(input logic [1:0] sel, input logic [7:0] c);
    lookup_t    lk;
    logic       is_dig;
    logic       is_low;
    logic       is_up;
    is_dig = (c >= CH_DIGIT0) && (c <= CH_DIGIT9);
    is_low = (c >= CH_LOWA) && (c <= CH_LOWZ);
    is_up  = (c >= CH_UPA) && (c <= CH_UPZ);
    lk = '0;
    case (sel)
      ALPHA_LCASE: begin
        lk.found = is_low;
        lk.pos   = 6'(c - CH_LOWA);
      end
      ALPHA_MIXED: begin
        lk.found = is_dig || is_low || is_up;
        if (is_dig) begin
          lk.pos = 6'(c - CH_DIGIT0);
        end else if (is_low) begin
          lk.pos = 6'(c - CH_LOWA) + LEN_DIGITS;
        end else begin
          lk.pos = 6'(c - CH_UPA) + LEN_DIGITS + LEN_LOWER;
        end
      end
      default: begin
        lk.found = is_dig;
        lk.pos   = 6'(c - CH_DIGIT0);
      end
    endcase
    return lk;
  endfunction

  // Character at a position of the selected alphabet
  function automatic logic [7:0] char_at(input logic [1:0] sel, input logic [5:0] idx);
    logic [7:0] ch;
    case (sel)
      ALPHA_LCASE: ch = CH_LOWA + 8'(idx);
      ALPHA_MIXED: begin
        if (idx < LEN_DIGITS) begin
          ch = CH_DIGIT0 + 8'(idx);
        end else if (idx < LEN_DIGITS + LEN_LOWER) begin
          ch = CH_LOWA + 8'(idx - LEN_DIGITS);
        end else begin
          ch = CH_UPA + 8'(idx - LEN_DIGITS - LEN_LOWER);
        end
      end
      default: ch = CH_DIGIT0 + 8'(idx);
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/alphabet_shift_cipher_core.sv */
// alphabet_shift_cipher_core: format-preserving shift cipher over a byte stream.
// The result is held in the single result register. Throughput: 1 item per cycle
//   unless result_ready is held low; the hash and the shift both settle in one pass.
// Key commands and code 3 produce no result; encrypt and decrypt give one result each.
// Reset (rst, synchronous): alphabet digits, key hash zero (shift of one), no result.
// Depends on ascip_pkg.
`default_nettype none

module alphabet_shift_cipher_core (
  input  wire                   clk,
  input  wire                   rst,
  // input items
  input  wire                   item_valid,
  output logic                  item_ready,
  input  wire ascip_pkg::item_t item,
  // results
  output logic                  result_valid,
  input  wire                   result_ready,
  output ascip_pkg::result_t    result,
  // alphabet select register
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [1:0]            cfg_data
);

  import ascip_pkg::*;

  logic [1:0] alphabet_select;
  logic [7:0] key_hash;
  logic [7:0] key_hash_next;

  logic       item_xfer;
  logic       is_key;
  logic       is_data;

  logic [8:0] shift_full;
  logic [5:0] shift_mod;
  logic [5:0] len;
  lookup_t    lk;
  logic [6:0] fwd_sum;
  logic [5:0] fwd_idx;
  logic [5:0] bwd_idx;
  logic [5:0] new_idx;
  result_t    result_next;

  // Register writes are always taken; write only while idle (the block does not enforce it).
  assign cfg_ready = 1'b1;

  // The result register frees itself when its transfer happens, so a new
  // item can enter in the same cycle.
  assign item_ready = !result_valid || result_ready;
  assign item_xfer  = item_valid && item_ready;

  assign is_key  = (item.command == CMD_KEY);
  assign is_data = (item.command == CMD_ENCRYPT) || (item.command == CMD_DECRYPT);

  // Running hash: h = 31h + c mod 256, optionally restarted from zero
  always_comb begin
    logic [7:0] base;
    base = item.key_start ? 8'd0 : key_hash;
    key_hash_next = 8'(base * HASH_MULT) + item.data_byte;
  end

  // Shift is hash + 1 (1..256), reduced modulo the alphabet length
  assign shift_full = {1'b0, key_hash} + 9'd1;
  assign len        = alphabet_size(alphabet_select);

  always_comb begin
    case (alphabet_select)
      ALPHA_LCASE: shift_mod = mod_const(shift_full, LEN_LOWER, RECIP_LOWER);
      ALPHA_MIXED: shift_mod = mod_const(shift_full, LEN_MIXED, RECIP_MIXED);
      default:     shift_mod = mod_const(shift_full, LEN_DIGITS, RECIP_DIGITS);
    endcase
  end

  assign lk = char_pos(alphabet_select, item.data_byte);

  // Forward: both operands below len, so one subtract wraps
  assign fwd_sum = 7'(lk.pos) + 7'(shift_mod);
  assign fwd_idx = (fwd_sum >= 7'(len)) ? 6'(fwd_sum - 7'(len)) : fwd_sum[5:0];
  // Backward: add len back when the difference would go negative
  assign bwd_idx = (lk.pos >= shift_mod) ? (lk.pos - shift_mod)
                                         : (lk.pos + len - shift_mod);

  assign new_idx = (item.command == CMD_ENCRYPT) ? fwd_idx : bwd_idx;

  always_comb begin
    result_next = '0;
    if (lk.found) begin
      result_next.out_byte = char_at(alphabet_select, new_idx);
      result_next.mapped   = 1'b1;
    end else begin
      // covers byte zero and anything else outside the alphabet
      result_next.out_byte = item.data_byte;
      result_next.mapped   = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_select <= ALPHA_DIGITS;
      key_hash        <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        alphabet_select <= cfg_data;
      end
      if (item_xfer && is_key) begin
        key_hash <= key_hash_next;
      end
      if (item_xfer) begin
        result_valid <= is_data;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (item_xfer && is_data) begin
      result <= result_next;
    end
  end

  // A shifted character is always alphanumeric
  a_mapped_alnum: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.mapped) |->
      ((result.out_byte >= CH_DIGIT0 && result.out_byte <= CH_DIGIT9) ||
       (result.out_byte >= CH_LOWA && result.out_byte <= CH_LOWZ) ||
       (result.out_byte >= CH_UPA && result.out_byte <= CH_UPZ)))
    else $error("mapped result outside alphanumerics");

  // Restarted key absorbs to the byte itself
  a_key_restart: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && is_key && item.key_start) |=> (key_hash == $past(item.data_byte)))
    else $error("key restart did not load the byte");

  // Data and unused commands leave the hash alone
  a_hash_hold: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && !is_key) |=> $stable(key_hash))
    else $error("hash changed on non-key command");

  // Every data transfer yields a pending result next cycle
  a_data_result: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && is_data) |=> result_valid)
    else $error("data transfer produced no result");

  // Key and unused commands yield no new result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && !is_data) |=> !result_valid)
    else $error("result raised for command without output");

endmodule

`default_nettype wire
